// ===== rtl/mprs_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the ring sequencer.
`default_nettype none

package mprs_pkg;

    localparam int RING_SIZE = 1024;
    localparam int SEQ_BITS  = 48;

    localparam int IDX_W  = $clog2(RING_SIZE);
    localparam int SEQ_W  = SEQ_BITS + 1;
    localparam int LAP_W  = SEQ_W - IDX_W;
    localparam int EXT_W  = SEQ_W + 2;
    localparam int STEP_W = IDX_W + 1;
    localparam int MODE_W = 3;
    localparam int CNT_W  = 11;
    localparam int STAT_W = 2;
    localparam int REM_W  = 11;

    localparam int IN_FIELDS_W  = CNT_W + 3 * SEQ_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = SEQ_W + 1 + REM_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic signed [SEQ_W-1:0] seq_t;
    typedef logic signed [EXT_W-1:0] ext_t;
    typedef logic [LAP_W-1:0]        lap_t;

    localparam seq_t SEQ_ONE     = seq_t'(1);
    localparam ext_t RING_EXT    = ext_t'(RING_SIZE);
    localparam ext_t SEQ_MAX_EXT = (ext_t'(1) <<< SEQ_BITS) - ext_t'(1);

    localparam logic [MODE_W-1:0] MODE_CLAIM   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUBLISH = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TEST    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SCAN    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SETCUR  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic              accept;
        logic              clr_wr;
        logic              claim_prep;
        logic              ptr_ld_lo;
        logic              ptr_inc;
        logic              pub_wr;
        logic              cur_ld_next;
        logic              cur_ld_lo;
        logic              cache_ld_cmin;
        logic              stat_ld;
        logic [STAT_W-1:0] stat_code;
        logic              avail_ld;
        logic              scan_res_fail;
        logic              rem_calc;
        logic              out_load;
    } mprs_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              clr_last;
        logic              cnt_bad;
        logic              claim_ovf;
        logic              claim_refresh;
        logic              wrap_gt_cmin;
        logic              pub_bad;
        logic              pub_last;
        logic              scan_go;
        logic              flag_match;
        logic              out_free;
    } mprs_stat_t;

endpackage

`default_nettype wire

// ===== rtl/mprs_dpath.sv =====
// Datapath: input registers, cursor and gating cache, slot lap-flag memory, output register.
`default_nettype none

module mprs_dpath
    import mprs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mprs_cmd_t         cmd,
    output mprs_stat_t             stat,
    input  wire logic [MODE_W-1:0] in_mode,
    input  wire logic [CNT_W-1:0]  in_count,
    input  wire seq_t              in_seq_lo,
    input  wire seq_t              in_seq_hi,
    input  wire seq_t              in_consumer_min,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic [STAT_W-1:0]      out_status,
    output seq_t                   out_result_seq,
    output logic                   out_is_available,
    output logic [REM_W-1:0]       out_remaining
);

    // Clamp anything below -1 up to -1.
    function automatic seq_t sat_seq(input seq_t x);
        return (x[SEQ_W-1] && (x != {SEQ_W{1'b1}})) ? {SEQ_W{1'b1}} : x;
    endfunction

    function automatic ext_t ext(input seq_t x);
        return {{(EXT_W-SEQ_W){x[SEQ_W-1]}}, x};
    endfunction

    // Arithmetic shift by log2 of the ring size.
    function automatic lap_t lap_of(input seq_t x);
        return x[SEQ_W-1:IDX_W];
    endfunction

    lap_t flag_mem [RING_SIZE];

    logic [MODE_W-1:0] mode_reg;
    logic [CNT_W-1:0]  cnt_reg;
    seq_t              lo_reg;
    seq_t              hi_reg;
    seq_t              cmin_reg;
    seq_t              cur_reg;
    seq_t              cache_reg;
    ext_t              next_reg;
    ext_t              wrap_reg;
    seq_t              ptr_reg;
    logic [STEP_W-1:0] steps_reg;
    seq_t              scan_res_reg;
    logic [STAT_W-1:0] status_reg;
    logic              avail_reg;
    ext_t              diff_reg;
    logic [IDX_W-1:0]  clr_addr_reg;
    lap_t              rd_data_reg;
    logic              out_valid_reg;

    ext_t cnt_ext;
    ext_t pub_diff;
    ext_t rem_full;

    assign cnt_ext  = {{(EXT_W-CNT_W){1'b0}}, cnt_reg};
    assign pub_diff = ext(hi_reg) - ext(lo_reg);

    always_comb
    begin
        if (diff_reg[EXT_W-1])
        begin
            rem_full = RING_EXT;
        end
        else if (diff_reg >= RING_EXT)
        begin
            rem_full = '0;
        end
        else
        begin
            rem_full = RING_EXT - diff_reg;
        end
    end

    always_comb
    begin
        stat.mode          = mode_reg;
        stat.clr_last      = (clr_addr_reg == {IDX_W{1'b1}});
        stat.cnt_bad       = (cnt_reg == '0) || (cnt_ext > RING_EXT);
        stat.claim_ovf     = (next_reg > SEQ_MAX_EXT);
        stat.claim_refresh = (wrap_reg > ext(cache_reg)) || (cache_reg > cur_reg);
        stat.wrap_gt_cmin  = (wrap_reg > ext(cmin_reg));
        stat.pub_bad       = pub_diff[EXT_W-1] || (pub_diff >= RING_EXT);
        stat.pub_last      = (ptr_reg == hi_reg);
        stat.scan_go       = (ptr_reg < hi_reg) && (steps_reg <= STEP_W'(RING_SIZE));
        stat.flag_match    = (rd_data_reg == lap_of(ptr_reg));
        stat.out_free      = !out_valid_reg || out_ready;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '1;
            cache_reg     <= '1;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cur_ld_next)
            begin
                cur_reg <= next_reg[SEQ_W-1:0];
            end
            else if (cmd.cur_ld_lo)
            begin
                cur_reg <= lo_reg;
            end
            if (cmd.cache_ld_cmin)
            begin
                cache_reg <= cmin_reg;
            end
            if (cmd.clr_wr)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg     <= in_mode;
            cnt_reg      <= in_count;
            lo_reg       <= sat_seq(in_seq_lo);
            hi_reg       <= sat_seq(in_seq_hi);
            cmin_reg     <= sat_seq(in_consumer_min);
            scan_res_reg <= sat_seq(in_seq_hi);
            status_reg   <= ST_OK;
            avail_reg    <= 1'b0;
        end
        if (cmd.claim_prep)
        begin
            next_reg <= ext(cur_reg) + cnt_ext;
            wrap_reg <= ext(cur_reg) + (cnt_ext - RING_EXT);
        end
        if (cmd.ptr_ld_lo)
        begin
            ptr_reg   <= lo_reg;
            steps_reg <= '0;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_reg   <= ptr_reg + SEQ_ONE;
            steps_reg <= steps_reg + 1'b1;
        end
        if (cmd.stat_ld)
        begin
            status_reg <= cmd.stat_code;
        end
        if (cmd.avail_ld)
        begin
            avail_reg <= stat.flag_match;
        end
        if (cmd.scan_res_fail)
        begin
            scan_res_reg <= ptr_reg - SEQ_ONE;
        end
        if (cmd.rem_calc)
        begin
            diff_reg <= ext(cur_reg) - ext(cmin_reg);
        end
        if (cmd.out_load)
        begin
            out_status       <= status_reg;
            out_result_seq   <= (mode_reg == MODE_SCAN) ? scan_res_reg : cur_reg;
            out_is_available <= avail_reg;
            out_remaining    <= rem_full[REM_W-1:0];
        end
    end

    // Lap-flag memory: one write port (clear sweep or publish), one registered read at ptr.
    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
        begin
            flag_mem[clr_addr_reg] <= {LAP_W{1'b1}};
        end
        else if (cmd.pub_wr)
        begin
            flag_mem[ptr_reg[IDX_W-1:0]] <= lap_of(ptr_reg);
        end
        rd_data_reg <= flag_mem[ptr_reg[IDX_W-1:0]];
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/mprs_ctrl.sv =====
// Controller state machine: sequences clear sweep, claim, publish, test and scan.
`default_nettype none

module mprs_ctrl
    import mprs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire mprs_stat_t stat,
    output mprs_cmd_t       cmd
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DECODE   = 4'd2;
    localparam logic [3:0] S_CLAIM    = 4'd3;
    localparam logic [3:0] S_PUB      = 4'd4;
    localparam logic [3:0] S_TEST_RD  = 4'd5;
    localparam logic [3:0] S_TEST_CMP = 4'd6;
    localparam logic [3:0] S_SCAN_CHK = 4'd7;
    localparam logic [3:0] S_SCAN_CMP = 4'd8;
    localparam logic [3:0] S_REM      = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.mode)
                    MODE_CLAIM:
                    begin
                        if (stat.cnt_bad)
                        begin
                            cmd.stat_ld   = 1'b1;
                            cmd.stat_code = ST_INVALID;
                            state_next    = S_REM;
                        end
                        else
                        begin
                            cmd.claim_prep = 1'b1;
                            state_next     = S_CLAIM;
                        end
                    end
                    MODE_PUBLISH:
                    begin
                        if (stat.pub_bad)
                        begin
                            cmd.stat_ld   = 1'b1;
                            cmd.stat_code = ST_INVALID;
                            state_next    = S_REM;
                        end
                        else
                        begin
                            cmd.ptr_ld_lo = 1'b1;
                            state_next    = S_PUB;
                        end
                    end
                    MODE_TEST:
                    begin
                        cmd.ptr_ld_lo = 1'b1;
                        state_next    = S_TEST_RD;
                    end
                    MODE_SCAN:
                    begin
                        cmd.ptr_ld_lo = 1'b1;
                        state_next    = S_SCAN_CHK;
                    end
                    MODE_SETCUR:
                    begin
                        cmd.cur_ld_lo = 1'b1;
                        state_next    = S_REM;
                    end
                    default:
                    begin
                        cmd.stat_ld   = 1'b1;
                        cmd.stat_code = ST_INVALID;
                        state_next    = S_REM;
                    end
                endcase
            end
            S_CLAIM:
            begin
                state_next = S_REM;
                priority if (stat.claim_ovf)
                begin
                    cmd.stat_ld   = 1'b1;
                    cmd.stat_code = ST_INVALID;
                end
                else if (stat.claim_refresh && stat.wrap_gt_cmin)
                begin
                    cmd.stat_ld   = 1'b1;
                    cmd.stat_code = ST_FULL;
                end
                else if (stat.claim_refresh)
                begin
                    cmd.cur_ld_next   = 1'b1;
                    cmd.cache_ld_cmin = 1'b1;
                end
                else
                begin
                    cmd.cur_ld_next = 1'b1;
                end
            end
            S_PUB:
            begin
                cmd.pub_wr = 1'b1;
                if (stat.pub_last)
                begin
                    state_next = S_REM;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            S_TEST_RD:
            begin
                state_next = S_TEST_CMP;
            end
            S_TEST_CMP:
            begin
                cmd.avail_ld = 1'b1;
                state_next   = S_REM;
            end
            S_SCAN_CHK:
            begin
                // flag read of ptr lands in the next cycle
                state_next = stat.scan_go ? S_SCAN_CMP : S_REM;
            end
            S_SCAN_CMP:
            begin
                if (stat.flag_match)
                begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_SCAN_CHK;
                end
                else
                begin
                    cmd.scan_res_fail = 1'b1;
                    state_next        = S_REM;
                end
            end
            S_REM:
            begin
                cmd.rem_calc = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/multi_producer_ring_sequencer.sv =====
// Top level of the multi-producer ring sequencer: stream ports, controller and datapath.
//
// One request comes in on the s_axis channel (s_axis_tuser carries the mode), one
// response goes out on m_axis per request (m_axis_tuser carries the status code).
// Modes: claim, publish a range, test one sequence, scan for the highest
// contiguous published sequence, force the cursor.
// Steps per request after accept: decode; a claim runs its check; publish makes one
// memory write per cycle over the range; test reads, then compares one flag; scan does one
// registered flag read and one compare per slot tested, at most RING_SIZE + 1 slots.
// Rejected counts and ranges, set cursor and invalid modes go from decode straight to
// the remaining step. Each request then computes remaining and loads its result;
// s_axis_tready returns in the cycle after that load, so a new request is taken only
// once the previous one's result is loaded. After reset the lap-flag memory is swept
// to all ones, one slot per cycle, over all RING_SIZE (1024) slots; s_axis_tready
// stays low during the sweep. Cursor and gating cache reset to -1.
// A result waits in the output register while m_axis_tready is low; the next
// request is still taken and worked on, and stalls only when its own result is
// ready to load while the previous one has not been transferred.
`default_nettype none

module multi_producer_ring_sequencer
    import mprs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // count[10:0], seq_lo[59:11], seq_hi[108:60], consumer_min[157:109], zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // mode[2:0]
    input  wire logic [MODE_W-1:0]      s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // result_seq[48:0], is_available[49], remaining[60:50], zero pad
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // status[1:0]
    output logic [STAT_W-1:0]           m_axis_tuser
);

    mprs_cmd_t         cmd;
    mprs_stat_t        stat;
    seq_t              result_seq;
    logic              is_available;
    logic [REM_W-1:0]  remaining;

    mprs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mprs_dpath u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .in_mode          (s_axis_tuser),
        .in_count         (s_axis_tdata[CNT_W-1:0]),
        .in_seq_lo        (s_axis_tdata[CNT_W+SEQ_W-1:CNT_W]),
        .in_seq_hi        (s_axis_tdata[CNT_W+2*SEQ_W-1:CNT_W+SEQ_W]),
        .in_consumer_min  (s_axis_tdata[CNT_W+3*SEQ_W-1:CNT_W+2*SEQ_W]),
        .out_ready        (m_axis_tready),
        .out_valid        (m_axis_tvalid),
        .out_status       (m_axis_tuser),
        .out_result_seq   (result_seq),
        .out_is_available (is_available),
        .out_remaining    (remaining)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, remaining, is_available,
                           result_seq};

endmodule

`default_nettype wire

// ===== tb/multi_producer_ring_sequencer_test.sv =====
// Self-checking testbench for the ring sequencer: directed table, random traffic, scoreboard.
`timescale 1ns / 1ps

module multi_producer_ring_sequencer_test;
    import mprs_pkg::*;

    localparam int    CLK_HALF     = 5;
    localparam int    RESET_CYCLES = 10;
    localparam int    RANDOM_ITEMS = 1800;
    localparam int    HOLD_OFF     = 400;
    localparam int    HOLD_AT      = 64;
    localparam int    DRAIN_CYCLES = 2200;
    localparam int    IDLE_LIMIT   = 12000;
    localparam int    SHOW_MAX     = 10;
    localparam longint SEQ_TOP_L   = (longint'(1) << SEQ_BITS) - 1;

    localparam seq_t NEG1    = seq_t'(-1);
    localparam seq_t SEQ_TOP = seq_t'(SEQ_TOP_L);
    localparam seq_t RAW_MIN = {1'b1, {SEQ_BITS{1'b0}}};

    // modes the block does not implement
    localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SEQ_W-1:0]  res;
        logic              avail;
        logic [REM_W-1:0]  rem;
    } seq_result_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CNT_W-1:0]  cnt;
        logic [SEQ_W-1:0]  lo;
        logic [SEQ_W-1:0]  hi;
        logic [SEQ_W-1:0]  cmin;
        logic              chk;
        seq_result_t       want;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [MODE_W-1:0]      s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STAT_W-1:0]      m_axis_tuser;

    // predictor state
    longint ring_cursor;
    longint gate_cache;
    longint lap_flag [RING_SIZE];

    // traffic shaping shadows: consumer position and next slot to publish
    longint cons_pos;
    longint pub_next;

    seq_result_t pending_results [$];
    int          req_count;
    int          rsp_count;
    int          fail_count;
    int          idle_cycles;

    multi_producer_ring_sequencer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    function automatic longint sat_seq(input seq_t raw);
        longint v;
        v = raw;
        if (v < -1)
            v = -1;
        return v;
    endfunction

    function automatic longint lap_for(input longint s);
        return s >>> IDX_W;
    endfunction

    function automatic int slot_for(input longint s);
        return int'(s & longint'(RING_SIZE - 1));
    endfunction

    function automatic seq_t rand_raw();
        return seq_t'({$urandom, $urandom});
    endfunction

    // Advance the sequencer state by one request and return its response.
    function automatic seq_result_t ring_step(input stim_row_t r);
        seq_result_t o;
        longint lo, hi, cmin, nxt, wrap, s, res, used;
        int steps;
        lo   = sat_seq(r.lo);
        hi   = sat_seq(r.hi);
        cmin = sat_seq(r.cmin);
        o = '0;
        o.status = ST_OK;
        res = ring_cursor;
        case (r.mode)
            MODE_CLAIM: begin
                if (r.cnt < 1 || r.cnt > RING_SIZE
                        || ring_cursor > SEQ_TOP_L - longint'(r.cnt)) begin
                    o.status = ST_INVALID;
                end else begin
                    nxt  = ring_cursor + longint'(r.cnt);
                    wrap = nxt - RING_SIZE;
                    if (wrap > gate_cache || gate_cache > ring_cursor) begin
                        // cached gate is stale: recheck against the live consumer minimum
                        if (wrap > cmin) begin
                            o.status = ST_FULL;
                        end else begin
                            gate_cache  = cmin;
                            ring_cursor = nxt;
                        end
                    end else begin
                        ring_cursor = nxt;
                    end
                end
                res = ring_cursor;
            end
            MODE_PUBLISH: begin
                if (hi < lo || hi - lo >= RING_SIZE)
                    o.status = ST_INVALID;
                else
                    for (s = lo; s <= hi; s++)
                        lap_flag[slot_for(s)] = lap_for(s);
            end
            MODE_TEST: begin
                o.avail = (lap_flag[slot_for(lo)] == lap_for(lo));
            end
            MODE_SCAN: begin
                res   = hi;
                steps = 0;
                s     = lo;
                while (s < hi && steps <= RING_SIZE) begin
                    if (lap_flag[slot_for(s)] != lap_for(s)) begin
                        res = s - 1;
                        break;
                    end
                    s++;
                    steps++;
                end
            end
            MODE_SETCUR: begin
                ring_cursor = lo;
                res = ring_cursor;
            end
            default: o.status = ST_INVALID;
        endcase
        o.res = res[SEQ_W-1:0];
        if (ring_cursor < cmin) begin
            o.rem = REM_W'(RING_SIZE);
        end else begin
            used  = ring_cursor - cmin;
            o.rem = (used >= RING_SIZE) ? '0 : REM_W'(RING_SIZE - used);
        end
        return o;
    endfunction

    function automatic stim_row_t req(input logic [MODE_W-1:0] mode, input int cnt,
                                      input seq_t lo, input seq_t hi, input seq_t cmin,
                                      input bit chk, input logic [STAT_W-1:0] st,
                                      input seq_t res, input bit av, input int rem);
        stim_row_t r;
        r.mode        = mode;
        r.cnt         = CNT_W'(cnt);
        r.lo          = lo;
        r.hi          = hi;
        r.cmin        = cmin;
        r.chk         = chk;
        r.want.status = st;
        r.want.res    = res;
        r.want.avail  = av;
        r.want.rem    = REM_W'(rem);
        return r;
    endfunction

    // Mostly well-formed producer traffic: claim, publish the claimed slots in order,
    // test and scan near the cursor; plus cursor jumps and raw noise.
    function automatic stim_row_t next_request();
        stim_row_t r;
        int pick;
        longint lo, hi;
        r = '0;
        if (cons_pos > ring_cursor || ring_cursor - cons_pos > RING_SIZE) begin
            cons_pos = ring_cursor - $urandom_range(0, RING_SIZE / 2);
            if (cons_pos < -1)
                cons_pos = -1;
            pub_next = cons_pos + 1;
        end
        if (pub_next > ring_cursor + 1)
            pub_next = ring_cursor + 1;
        cons_pos += $urandom_range(0, 12);
        if (cons_pos > pub_next - 1)
            cons_pos = pub_next - 1;
        r.cmin = seq_t'(cons_pos);
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            r.mode = MODE_CLAIM;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                r.cnt = '0;
            else if (pick < 6)
                r.cnt = CNT_W'($urandom_range(RING_SIZE + 1, (1 << CNT_W) - 1));
            else if (pick < 12)
                r.cnt = CNT_W'($urandom_range(1, RING_SIZE));
            else
                r.cnt = CNT_W'($urandom_range(1, 16));
        end else if (pick < 55) begin
            r.mode = MODE_PUBLISH;
            if (pub_next <= ring_cursor) begin
                hi = pub_next + $urandom_range(0, 15);
                if (hi > ring_cursor)
                    hi = ring_cursor;
                lo = pub_next;
                // now and then skip a slot so later scans stop at a hole
                if ($urandom_range(0, 9) == 0 && lo < hi)
                    lo++;
                pub_next = hi + 1;
            end else begin
                lo = ring_cursor - $urandom_range(0, 8);
                hi = lo + $urandom_range(0, 3);
                if ($urandom_range(0, 3) == 0)
                    hi = lo - 1 - $urandom_range(0, 3);
                else if ($urandom_range(0, 3) == 0)
                    hi = lo + RING_SIZE + $urandom_range(0, 3);
            end
            r.lo = seq_t'(lo);
            r.hi = seq_t'(hi);
        end else if (pick < 70) begin
            r.mode = MODE_TEST;
            r.lo = seq_t'(ring_cursor + 4 - $urandom_range(0, RING_SIZE + 64));
        end else if (pick < 85) begin
            r.mode = MODE_SCAN;
            lo = cons_pos + 1 - $urandom_range(0, 2);
            hi = ring_cursor + $urandom_range(0, 3);
            if ($urandom_range(0, 9) == 0)
                hi = lo - $urandom_range(0, 3);
            r.lo = seq_t'(lo);
            r.hi = seq_t'(hi);
        end else if (pick < 90) begin
            r.mode = MODE_SETCUR;
            case ($urandom_range(0, 3))
                0: r.lo = seq_t'(ring_cursor + $urandom_range(0, 64));
                1: r.lo = seq_t'(SEQ_TOP_L - $urandom_range(0, 3000));
                2: r.lo = NEG1;
                default: r.lo = rand_raw();
            endcase
        end else begin
            r.mode = MODE_W'($urandom_range(0, (1 << MODE_W) - 1));
            r.cnt  = CNT_W'($urandom);
            r.lo   = rand_raw();
            r.hi   = rand_raw();
            r.cmin = rand_raw();
        end
        if (r.mode != MODE_CLAIM && $urandom_range(0, 9) == 0)
            r.cmin = $urandom_range(0, 1) ? rand_raw()
                                          : seq_t'(ring_cursor - 1100 + $urandom_range(0, 2200));
        return r;
    endfunction

    task automatic send_item(input stim_row_t r);
        int gap;
        seq_result_t want;
        gap = (req_count % 100 < 20) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.mode;
        s_axis_tdata  <= IN_TDATA_W'({r.cmin, r.hi, r.lo, r.cnt});
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        want = ring_step(r);
        if (r.chk)
            want = r.want;
        pending_results.push_back(want);
        req_count++;
    endtask

    // request side
    initial begin
        stim_row_t dir_rows [$];
        stim_row_t r;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= MODE_CLAIM;
        rst_n         <= 1'b0;
        ring_cursor = -1;
        gate_cache  = -1;
        for (int i = 0; i < RING_SIZE; i++)
            lap_flag[i] = -1;
        cons_pos  = -1;
        pub_next  = 0;
        req_count = 0;

        // empty ring, bad counts and modes, saturation of sequences
        dir_rows.push_back(req(MODE_CLAIM,   0,    NEG1, NEG1, NEG1, 1, ST_INVALID, NEG1, 0, 1024));
        dir_rows.push_back(req(MODE_CLAIM,   1025, NEG1, NEG1, NEG1, 1, ST_INVALID, NEG1, 0, 1024));
        dir_rows.push_back(req(MODE_CLAIM,   2047, NEG1, NEG1, NEG1, 1, ST_INVALID, NEG1, 0, 1024));
        dir_rows.push_back(req(MODE_SPARE_5, 0,    NEG1, NEG1, NEG1, 1, ST_INVALID, NEG1, 0, 1024));
        dir_rows.push_back(req(MODE_SPARE_7, 0,    NEG1, NEG1, NEG1, 1, ST_INVALID, NEG1, 0, 1024));
        dir_rows.push_back(req(MODE_TEST,    0,    NEG1, NEG1, NEG1, 1, ST_OK, NEG1, 1, 1024));
        dir_rows.push_back(req(MODE_TEST,    0,    seq_t'(0), NEG1, NEG1, 1, ST_OK, NEG1, 0, 1024));
        dir_rows.push_back(req(MODE_TEST,    0,    SEQ_TOP, NEG1, NEG1, 1, ST_OK, NEG1, 0, 1024));
        dir_rows.push_back(req(MODE_TEST,    0,    RAW_MIN, NEG1, NEG1, 1, ST_OK, NEG1, 1, 1024));
        // scan whose low bound is not below the upper bound returns the upper bound
        dir_rows.push_back(req(MODE_SCAN, 0, seq_t'(5), seq_t'(3), NEG1, 1,
                               ST_OK, seq_t'(3), 0, 1024));
        // fill the ring, then run out of room, then refresh the gate and go on
        dir_rows.push_back(req(MODE_CLAIM, 1024, NEG1, NEG1, NEG1, 1, ST_OK, seq_t'(1023), 0, 0));
        dir_rows.push_back(req(MODE_CLAIM, 1, NEG1, NEG1, NEG1, 1, ST_FULL, seq_t'(1023), 0, 0));
        dir_rows.push_back(req(MODE_CLAIM, 1, NEG1, NEG1, seq_t'(0), 1,
                               ST_OK, seq_t'(1024), 0, 0));
        dir_rows.push_back(req(MODE_PUBLISH, 0, seq_t'(0), seq_t'(1023), seq_t'(0), 1,
                               ST_OK, seq_t'(1024), 0, 0));
        dir_rows.push_back(req(MODE_PUBLISH, 0, seq_t'(0), seq_t'(1024), seq_t'(0), 1,
                               ST_INVALID, seq_t'(1024), 0, 0));
        dir_rows.push_back(req(MODE_PUBLISH, 0, seq_t'(10), seq_t'(9), seq_t'(0), 1,
                               ST_INVALID, seq_t'(1024), 0, 0));
        // whole ring published: scan walks every slot and stops at the next lap
        dir_rows.push_back(req(MODE_SCAN, 0, seq_t'(0), seq_t'(2000), seq_t'(0), 1,
                               ST_OK, seq_t'(1023), 0, 0));
        dir_rows.push_back(req(MODE_PUBLISH, 0, seq_t'(1024), seq_t'(1024), seq_t'(0), 0,
                               ST_OK, NEG1, 0, 0));
        dir_rows.push_back(req(MODE_SCAN, 0, seq_t'(-5), seq_t'(10), seq_t'(0), 0,
                               ST_OK, NEG1, 0, 0));
        dir_rows.push_back(req(MODE_TEST, 0, seq_t'(1024), NEG1, seq_t'(512), 0,
                               ST_OK, NEG1, 0, 0));
        // cursor at the largest sequence: any further claim overflows
        dir_rows.push_back(req(MODE_SETCUR, 0, SEQ_TOP, NEG1, NEG1, 1, ST_OK, SEQ_TOP, 0, 0));
        dir_rows.push_back(req(MODE_CLAIM, 1, NEG1, NEG1, NEG1, 1, ST_INVALID, SEQ_TOP, 0, 0));
        dir_rows.push_back(req(MODE_SETCUR, 0, NEG1, NEG1, SEQ_TOP, 1, ST_OK, NEG1, 0, 1024));
        dir_rows.push_back(req(MODE_SETCUR, 0, RAW_MIN, RAW_MIN, RAW_MIN, 0, ST_OK, NEG1, 0, 0));
        dir_rows.push_back(req(MODE_SETCUR, 0, seq_t'(1024), NEG1, seq_t'(1024), 0,
                               ST_OK, NEG1, 0, 0));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i]);
        cons_pos = 1024;
        pub_next = 1025;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            r = next_request();
            send_item(r);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("multi_producer_ring_sequencer verification clean");
        else
            $display("multi_producer_ring_sequencer verification failed");
        $finish;
    end

    // response side
    initial begin
        int gap;
        seq_result_t got;
        seq_result_t want;
        m_axis_tready <= 1'b0;
        rsp_count  = 0;
        fail_count = 0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever begin
            gap = (rsp_count % 90 < 25) ? 0 : $urandom_range(0, 15);
            // one long back-pressure stretch so the block fills and stalls its input
            if (rsp_count == HOLD_AT)
                gap = HOLD_OFF;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_axis_tvalid !== 1'b1);
            got.status = m_axis_tuser;
            got.res    = m_axis_tdata[SEQ_W-1:0];
            got.avail  = m_axis_tdata[SEQ_W];
            got.rem    = m_axis_tdata[SEQ_W+1 +: REM_W];
            if (pending_results.size() == 0) begin
                if (fail_count < SHOW_MAX)
                    $display("unexpected result transfer %0d: status %0d seq %0d", rsp_count,
                             got.status, $signed(got.res));
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.res !== want.res
                        || got.avail !== want.avail || got.rem !== want.rem) begin
                    if (fail_count < SHOW_MAX)
                        $display({"result %0d mismatch: expected status %0d seq %0d avail %0d ",
                                  "rem %0d, got status %0d seq %0d avail %0d rem %0d"},
                                 rsp_count, want.status, $signed(want.res), want.avail,
                                 want.rem, got.status, $signed(got.res), got.avail, got.rem);
                    fail_count++;
                end
            end
            rsp_count++;
        end
    end

    // watchdog on cycles without any transfer
    initial idle_cycles = 0;
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("multi_producer_ring_sequencer verification failed");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
rtl/mprs_pkg.sv
rtl/mprs_dpath.sv
rtl/mprs_ctrl.sv
rtl/multi_producer_ring_sequencer.sv
tb/multi_producer_ring_sequencer_test.sv
